// File: rtl/core/point_in_oriented_box_test_unit_defines.svh
// Assertion macros for the point-in-box tester
`ifndef POINT_IN_ORIENTED_BOX_TEST_UNIT_DEFINES_SVH
`define POINT_IN_ORIENTED_BOX_TEST_UNIT_DEFINES_SVH

// implication checked in the following cycle
`define PIBT_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("pibt: check failed");

// implication checked in the same cycle
`define PIBT_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("pibt: check failed");

`endif

// File: rtl/core/pibt_pkg.sv
// Types, constants and plane tables of the point-in-box tester
package pibt_pkg;

	localparam int NumPlanes = 6;
	localparam int CoordW    = 16;
	localparam int CofW      = 34;
	localparam int PW        = 35;
	localparam int SplitW    = 17;
	localparam int HalfW     = PW - SplitW;
	localparam int PartW     = HalfW + CofW;
	localparam int ProdW     = CoordW + CofW;
	localparam int SumW      = ProdW + 2;
	localparam int KW        = 72;
	localparam int AddrW     = 6;
	localparam int DataW     = 64;
	localparam int CntW      = 3;
	localparam logic [CntW-1:0] SettleCycles = 3'd6;

	localparam logic [2:0] RegBoxMin = 3'd0;
	localparam logic [2:0] RegBoxMax = 3'd1;
	localparam logic [2:0] RegRow0   = 3'd2;
	localparam logic [2:0] RegRow1   = 3'd3;
	localparam logic [2:0] RegRow2   = 3'd4;

	// corner on each face (bit0 x, bit1 y, bit2 z, 1 = max), normal column, extent negate
	localparam logic [2:0] PlaneCorner [NumPlanes] = '{3'd4, 3'd0, 3'd1, 3'd5, 3'd6, 3'd4};
	localparam int         PlaneCol    [NumPlanes] = '{2, 0, 2, 0, 1, 1};
	localparam logic       PlaneNeg    [NumPlanes] = '{1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 1'b1};
	localparam int         NextAx      [3]         = '{1, 2, 0};
	localparam int         PrevAx      [3]         = '{2, 0, 1};

	typedef struct packed {
		logic                     last_vertex;
		logic signed [CoordW-1:0] vertex_z;
		logic signed [CoordW-1:0] vertex_y;
		logic signed [CoordW-1:0] vertex_x;
	} vtx_t;

	typedef struct packed {
		logic last_result;
		logic inside_res;
	} res_t;

	typedef struct packed {
		logic [47:0]      box_min;
		logic [47:0]      box_max;
		logic [2:0][63:0] mat;
	} cfg_t;

	// cof indexed [column][row]
	typedef struct packed {
		logic [2:0][2:0][CofW-1:0]       cof;
		logic [NumPlanes-1:0][KW-1:0]    k;
		logic [NumPlanes-1:0]            ok;
		logic [NumPlanes-1:0]            flip;
	} geom_t;

endpackage

// File: rtl/core/point_in_oriented_box_test_unit.sv
// Point-in-oriented-box tester, top level
// Tests world-space vertices against a box carried into world space by an affine matrix.
// Configuration: APB port, 64-bit data, register i at byte address 8*i (box_min, box_max,
//   matrix_row0..2). pready is always high; a write lands in the access cycle.
// Input channel in_valid/in_stall/in_word moves one vertex word; output channel
//   out_valid/out_stall/out_word moves one result word per vertex, in order.
// Throughput: one vertex per cycle while out_stall is low and the plane setup is not busy,
//   through the four-stage vertex pipeline (input, products, sums, face compare).
// After reset and after any register write, in_stall stays high until busy clears
//   while the five-stage plane setup (cofactors, face points, split offset products) settles.
// Reset clears the configuration registers to zero: the box is degenerate and every
//   vertex reports outside until the box and matrix are written.
// A stalled output holds its word; the stall backs up stage by stage, so empty stages
//   still fill and the stall raises in_stall only once every stage holds a word.
module point_in_oriented_box_test_unit (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [pibt_pkg::AddrW-1:0]  paddr,
	input  logic [pibt_pkg::DataW-1:0]  pwdata,
	output logic [pibt_pkg::DataW-1:0]  prdata,
	output logic                        pready,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  pibt_pkg::vtx_t              in_word,
	output logic                        out_valid,
	input  logic                        out_stall,
	output pibt_pkg::res_t              out_word
);
	pibt_pkg::cfg_t  cfg;
	pibt_pkg::geom_t geom;
	logic            busy;
	logic            ready;

	assign pready = 1'b1;

	pibt_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.cfg     (cfg),
		.busy    (busy)
	);

	pibt_planes u_planes (
		.clk  (clk),
		.cfg  (cfg),
		.geom (geom)
	);

	pibt_vtx u_vtx (
		.clk        (clk),
		.arst_n     (arst_n),
		.geom       (geom),
		.item_valid (in_valid && !busy),
		.item       (in_word),
		.ready      (ready),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_word   (out_word)
	);

	assign in_stall = busy || !ready;

`include "point_in_oriented_box_test_unit_defines.svh"

	`PIBT_ASSERT_NEXT(a_cfg_blocks_input, psel && penable && pwrite, in_stall)
	`PIBT_ASSERT_NEXT(a_latency, (in_valid && !in_stall) ##1 !out_stall ##1 !out_stall ##1 !out_stall, out_valid)
	`PIBT_ASSERT_NOW(a_ready_when_empty, !busy && !out_valid && !in_stall, !in_stall)

endmodule

// File: rtl/core/pibt_cfg.sv
// APB register file and plane settle counter
module pibt_cfg (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [pibt_pkg::AddrW-1:0]    paddr,
	input  logic [pibt_pkg::DataW-1:0]    pwdata,
	output logic [pibt_pkg::DataW-1:0]    prdata,
	output pibt_pkg::cfg_t                cfg,
	output logic                          busy
);
	logic [47:0]                 box_min_q, box_max_q;
	logic [2:0][63:0]            mat_q;
	logic [pibt_pkg::CntW-1:0]   cnt_q;
	logic [2:0]                  idx;
	logic                        wr;

	assign idx = paddr[pibt_pkg::AddrW-1:3];
	assign wr  = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			box_min_q <= '0;
			box_max_q <= '0;
			mat_q     <= '0;
			cnt_q     <= pibt_pkg::SettleCycles;
		end else begin
			if (wr) begin
				cnt_q <= pibt_pkg::SettleCycles;
				case (idx)
					pibt_pkg::RegBoxMin: box_min_q <= pwdata[47:0];
					pibt_pkg::RegBoxMax: box_max_q <= pwdata[47:0];
					pibt_pkg::RegRow0:   mat_q[0]  <= pwdata;
					pibt_pkg::RegRow1:   mat_q[1]  <= pwdata;
					pibt_pkg::RegRow2:   mat_q[2]  <= pwdata;
					default: ;
				endcase
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_comb begin
		case (idx)
			pibt_pkg::RegBoxMin: prdata = {16'd0, box_min_q};
			pibt_pkg::RegBoxMax: prdata = {16'd0, box_max_q};
			pibt_pkg::RegRow0:   prdata = mat_q[0];
			pibt_pkg::RegRow1:   prdata = mat_q[1];
			pibt_pkg::RegRow2:   prdata = mat_q[2];
			default:             prdata = '0;
		endcase
	end

	assign cfg.box_min = box_min_q;
	assign cfg.box_max = box_max_q;
	assign cfg.mat     = mat_q;
	assign busy        = cnt_q != '0;

endmodule

// File: rtl/core/pibt_planes.sv
// Face plane setup: cofactor normals, face offsets and validity, five register stages
module pibt_planes (
	input  logic            clk,
	input  pibt_pkg::cfg_t  cfg,
	output pibt_pkg::geom_t geom
);
	localparam int NP     = pibt_pkg::NumPlanes;
	localparam int CofW   = pibt_pkg::CofW;
	localparam int PW     = pibt_pkg::PW;
	localparam int SplitW = pibt_pkg::SplitW;
	localparam int PartW  = pibt_pkg::PartW;
	localparam int KW     = pibt_pkg::KW;

	logic signed [15:0] m [3][4];
	logic signed [15:0] lo [3];
	logic signed [15:0] hi [3];
	logic signed [16:0] ext [3];

	logic signed [31:0] pa_c1 [3][3];
	logic signed [31:0] pb_c1 [3][3];
	logic signed [31:0] mlo_c1 [3][3];
	logic signed [31:0] mhi_c1 [3][3];
	logic signed [15:0] t_c1 [3];
	logic [2:0]         eneg_c1, ezero_c1;

	logic signed [CofW-1:0] cof_c2 [3][3];
	logic signed [PW-1:0]   p_c2 [NP][3];
	logic [NP-1:0]          fsok_c2, flip_c2;

	logic signed [PartW-1:0] pl_c3 [NP][3];
	logic signed [PartW-1:0] ph_c3 [NP][3];
	logic [NP-1:0]           ok_c3, flip_c3;

	logic signed [KW-1:0] kr_c4 [NP][3];
	logic [NP-1:0]        ok_c4, flip_c4;

	logic signed [KW-1:0] k_c5 [NP];
	logic [NP-1:0]        ok_c5, flip_c5;

	always_comb begin
		for (int r = 0; r < 3; r++) begin
			for (int c = 0; c < 4; c++) begin
				m[r][c] = $signed(cfg.mat[r][16*c +: 16]);
			end
		end
		for (int c = 0; c < 3; c++) begin
			lo[c]  = $signed(cfg.box_min[16*c +: 16]);
			hi[c]  = $signed(cfg.box_max[16*c +: 16]);
			ext[c] = 17'(hi[c]) - 17'(lo[c]);
		end
	end

	// c1: all 16x16 products
	always_ff @(posedge clk) begin
		for (int c = 0; c < 3; c++) begin
			for (int r = 0; r < 3; r++) begin
				pa_c1[c][r]  <= m[pibt_pkg::NextAx[r]][pibt_pkg::NextAx[c]]
					* m[pibt_pkg::PrevAx[r]][pibt_pkg::PrevAx[c]];
				pb_c1[c][r]  <= m[pibt_pkg::PrevAx[r]][pibt_pkg::NextAx[c]]
					* m[pibt_pkg::NextAx[r]][pibt_pkg::PrevAx[c]];
				mlo_c1[r][c] <= m[r][c] * lo[c];
				mhi_c1[r][c] <= m[r][c] * hi[c];
			end
			t_c1[c]     <= m[c][3];
			eneg_c1[c]  <= ext[c][16];
			ezero_c1[c] <= ext[c] == '0;
		end
	end

	// c2: cofactors, face points, extent signs
	always_ff @(posedge clk) begin
		for (int c = 0; c < 3; c++) begin
			for (int r = 0; r < 3; r++) begin
				cof_c2[c][r] <= CofW'(pa_c1[c][r]) - CofW'(pb_c1[c][r]);
			end
		end
		for (int i = 0; i < NP; i++) begin
			for (int r = 0; r < 3; r++) begin
				p_c2[i][r] <=
					(pibt_pkg::PlaneCorner[i][0] ? PW'(mhi_c1[r][0]) : PW'(mlo_c1[r][0]))
					+ (pibt_pkg::PlaneCorner[i][1] ? PW'(mhi_c1[r][1]) : PW'(mlo_c1[r][1]))
					+ (pibt_pkg::PlaneCorner[i][2] ? PW'(mhi_c1[r][2]) : PW'(mlo_c1[r][2]))
					+ (PW'(t_c1[r]) <<< 8);
			end
			fsok_c2[i] <= !ezero_c1[pibt_pkg::NextAx[pibt_pkg::PlaneCol[i]]]
				&& !ezero_c1[pibt_pkg::PrevAx[pibt_pkg::PlaneCol[i]]];
			flip_c2[i] <= eneg_c1[pibt_pkg::NextAx[pibt_pkg::PlaneCol[i]]]
				^ eneg_c1[pibt_pkg::PrevAx[pibt_pkg::PlaneCol[i]]]
				^ pibt_pkg::PlaneNeg[i];
		end
	end

	// c3: face offset products, split in two halves
	always_ff @(posedge clk) begin
		for (int i = 0; i < NP; i++) begin
			for (int r = 0; r < 3; r++) begin
				pl_c3[i][r] <= $signed({1'b0, p_c2[i][r][SplitW-1:0]})
					* cof_c2[pibt_pkg::PlaneCol[i]][r];
				ph_c3[i][r] <= $signed(p_c2[i][r][PW-1:SplitW])
					* cof_c2[pibt_pkg::PlaneCol[i]][r];
			end
			ok_c3[i]   <= fsok_c2[i] && ((cof_c2[pibt_pkg::PlaneCol[i]][0] != '0)
				|| (cof_c2[pibt_pkg::PlaneCol[i]][1] != '0)
				|| (cof_c2[pibt_pkg::PlaneCol[i]][2] != '0));
			flip_c3[i] <= flip_c2[i];
		end
	end

	// c4: recombine halves
	always_ff @(posedge clk) begin
		for (int i = 0; i < NP; i++) begin
			for (int r = 0; r < 3; r++) begin
				kr_c4[i][r] <= (KW'(ph_c3[i][r]) <<< SplitW) + KW'(pl_c3[i][r]);
			end
		end
		ok_c4   <= ok_c3;
		flip_c4 <= flip_c3;
	end

	// c5: offset per face
	always_ff @(posedge clk) begin
		for (int i = 0; i < NP; i++) begin
			k_c5[i] <= kr_c4[i][0] + kr_c4[i][1] + kr_c4[i][2];
		end
		ok_c5   <= ok_c4;
		flip_c5 <= flip_c4;
	end

	always_comb begin
		for (int c = 0; c < 3; c++) begin
			for (int r = 0; r < 3; r++) begin
				geom.cof[c][r] = cof_c2[c][r];
			end
		end
		for (int i = 0; i < NP; i++) begin
			geom.k[i] = k_c5[i];
		end
		geom.ok   = ok_c5;
		geom.flip = flip_c5;
	end

endmodule

// File: rtl/core/pibt_vtx.sv
// Vertex pipeline: normal products, dot sums, face compare
module pibt_vtx (
	input  logic            clk,
	input  logic            arst_n,
	input  pibt_pkg::geom_t geom,
	input  logic            item_valid,
	input  pibt_pkg::vtx_t  item,
	output logic            ready,
	output logic            out_valid,
	input  logic            out_stall,
	output pibt_pkg::res_t  out_word
);
	localparam int NP    = pibt_pkg::NumPlanes;
	localparam int ProdW = pibt_pkg::ProdW;
	localparam int SumW  = pibt_pkg::SumW;
	localparam int KW    = pibt_pkg::KW;

	logic                   v_s1, v_s2, v_s3, v_s4;
	logic                   en1, en2, en3, en4;
	pibt_pkg::vtx_t         vtx_s1;
	logic signed [15:0]     vec [3];
	logic signed [ProdW-1:0] prod_s2 [3][3];
	logic                   last_s2, last_s3;
	logic signed [SumW-1:0] sum_s3 [3];
	pibt_pkg::res_t         res_s4;
	logic signed [KW-1:0]   dot [NP];
	logic [NP-1:0]          face_in;

	// a stage moves when it is empty or the next one moves
	assign en4   = !v_s4 || !out_stall;
	assign en3   = !v_s3 || en4;
	assign en2   = !v_s2 || en3;
	assign en1   = !v_s1 || en2;
	assign ready = en1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (en1) v_s1 <= item_valid;
			if (en2) v_s2 <= v_s1;
			if (en3) v_s3 <= v_s2;
			if (en4) v_s4 <= v_s3;
		end
	end

	assign vec[0] = vtx_s1.vertex_x;
	assign vec[1] = vtx_s1.vertex_y;
	assign vec[2] = vtx_s1.vertex_z;

	always_ff @(posedge clk) begin
		if (en1 && item_valid) vtx_s1 <= item;
		if (en2 && v_s1) begin
			for (int c = 0; c < 3; c++) begin
				for (int r = 0; r < 3; r++) begin
					prod_s2[c][r] <= vec[r] * $signed(geom.cof[c][r]);
				end
			end
			last_s2 <= vtx_s1.last_vertex;
		end
		if (en3 && v_s2) begin
			for (int c = 0; c < 3; c++) begin
				sum_s3[c] <= SumW'(prod_s2[c][0]) + SumW'(prod_s2[c][1])
					+ SumW'(prod_s2[c][2]);
			end
			last_s3 <= last_s2;
		end
		if (en4 && v_s3) begin
			res_s4.inside_res  <= &face_in;
			res_s4.last_result <= last_s3;
		end
	end

	// vertex scaled to Q.20 against the face offset; on the face counts as inside
	always_comb begin
		for (int i = 0; i < NP; i++) begin
			dot[i] = (KW'(sum_s3[pibt_pkg::PlaneCol[i]]) <<< 12) - $signed(geom.k[i]);
			face_in[i] = geom.ok[i] && (geom.flip[i] ? !dot[i][KW-1]
				: (dot[i][KW-1] || dot[i] == '0));
		end
	end

	assign out_valid = v_s4;
	assign out_word  = res_s4;

endmodule
